// ----- sv/idtlv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idtlv_pkg
// Shared types and constants of the identity TLV stream parser: record type
// codes, destination codes, parse phases and the beat layouts.
// ----------------------------------------------------------------------------
package idtlv_pkg;

  // Record type codes carried in the type byte, and the open bracket that marks an IP host
  localparam logic [7:0] TYPE_NAME    = 8'h01;
  localparam logic [7:0] TYPE_GROUPS  = 8'h04;
  localparam logic [7:0] TYPE_RANDOM  = 8'h07;
  localparam logic [7:0] TYPE_HOST    = 8'h20;
  localparam logic [7:0] OPEN_BRACKET = 8'h5B;

  // Block status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
  localparam logic [1:0] STATUS_NO_FIELDS = 2'd2;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    DEST_NONE   = 3'd0,
    DEST_NAME   = 3'd1,
    DEST_GROUPS = 3'd2,
    DEST_HOST   = 3'd3,
    DEST_IP     = 3'd4
  } dest_e;

  typedef enum logic [1:0] {
    PH_TYPE   = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_LEN_LO = 2'd2,
    PH_VALUE  = 2'd3
  } phase_e;

  // One input beat
  typedef struct packed {
    logic       last_byte;
    logic       has_byte;
    logic [7:0] data_byte;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [15:0] field_count;
    logic [1:0]  status;
    logic        block_done;
    logic [8:0]  field_length;
    logic        field_end;
    logic        field_start;
    logic [8:0]  write_index;
    logic [7:0]  write_byte;
    dest_e       dest;
    logic        write_enable;
  } result_t;

endpackage

// ----- sv/idtlv_slice.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idtlv_slice
// One register stage of a stream: holds a beat until the next stage takes it
// and accepts a new beat in the same cycle the held one leaves.
// ----------------------------------------------------------------------------
module idtlv_slice #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [W-1:0] data_o
);

  logic         valid_q;
  logic [W-1:0] data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Hold the beat flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Load payload on each taken beat
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

// ----- sv/idtlv_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idtlv_core
// Record parser: phase, length and position state plus the combinational
// logic that turns one input beat into one result beat.
// ----------------------------------------------------------------------------
module idtlv_core #(
  parameter int unsigned NAME_CAPACITY   = 256,
  parameter int unsigned GROUPS_CAPACITY = 512,
  parameter int unsigned HOST_CAPACITY   = 256,
  parameter int unsigned IP_CAPACITY     = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  idtlv_pkg::item_t    item_i,
  output idtlv_pkg::result_t  result_o
);

  localparam int unsigned MAX_NG  = (NAME_CAPACITY > GROUPS_CAPACITY) ?
                                    NAME_CAPACITY : GROUPS_CAPACITY;
  localparam int unsigned MAX_HI  = (HOST_CAPACITY > IP_CAPACITY) ?
                                    HOST_CAPACITY : IP_CAPACITY;
  localparam int unsigned MAX_CAP = (MAX_NG > MAX_HI) ? MAX_NG : MAX_HI;
  localparam int unsigned POS_W   = $clog2(MAX_CAP + 1);

  localparam logic [POS_W-1:0] CAP_NAME   = POS_W'(NAME_CAPACITY);
  localparam logic [POS_W-1:0] CAP_GROUPS = POS_W'(GROUPS_CAPACITY);
  localparam logic [POS_W-1:0] CAP_HOST   = POS_W'(HOST_CAPACITY);
  localparam logic [POS_W-1:0] CAP_IP     = POS_W'(IP_CAPACITY);
  localparam logic [POS_W-1:0] CAP_NONE   = POS_W'(1);

  function automatic logic [POS_W-1:0] cap_of(idtlv_pkg::dest_e d);
    logic [POS_W-1:0] c;
    case (d)
      idtlv_pkg::DEST_NAME:   c = CAP_NAME;
      idtlv_pkg::DEST_GROUPS: c = CAP_GROUPS;
      idtlv_pkg::DEST_HOST:   c = CAP_HOST;
      idtlv_pkg::DEST_IP:     c = CAP_IP;
      default:                c = CAP_NONE;
    endcase
    return c;
  endfunction

  function automatic idtlv_pkg::dest_e dest_of_type(logic [7:0] t);
    idtlv_pkg::dest_e d;
    case (t)
      idtlv_pkg::TYPE_NAME:   d = idtlv_pkg::DEST_NAME;
      idtlv_pkg::TYPE_GROUPS: d = idtlv_pkg::DEST_GROUPS;
      idtlv_pkg::TYPE_HOST:   d = idtlv_pkg::DEST_HOST;
      default:                d = idtlv_pkg::DEST_NONE;
    endcase
    return d;
  endfunction

  idtlv_pkg::phase_e phase_q, phase_d;
  logic [7:0]        type_q, type_d;
  logic [15:0]       left_q, left_d;
  idtlv_pkg::dest_e  dest_q, dest_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [15:0]       count_q, count_d;

  idtlv_pkg::dest_e  cur_dest;
  logic [POS_W-1:0]  cap;
  logic [POS_W-1:0]  pos_next;
  logic [POS_W-1:0]  raw_len;
  logic [15:0]       len_full;
  logic [15:0]       left_next;
  idtlv_pkg::dest_e  type_dest;

  // Next state and result for the beat at the head of the input stage
  always_comb begin
    phase_d   = phase_q;
    type_d    = type_q;
    left_d    = left_q;
    dest_d    = dest_q;
    pos_d     = pos_q;
    count_d   = count_q;
    result_o  = '0;
    len_full  = {left_q[15:8], item_i.data_byte};
    type_dest = dest_of_type(type_q);
    cur_dest  = dest_q;
    if (pos_q == '0 && dest_q == idtlv_pkg::DEST_HOST &&
        item_i.data_byte == idtlv_pkg::OPEN_BRACKET) begin
      cur_dest = idtlv_pkg::DEST_IP;
    end
    cap       = cap_of(cur_dest);
    pos_next  = (pos_q < cap) ? pos_q + POS_W'(1) : pos_q;
    left_next = (left_q != '0) ? left_q - 16'd1 : left_q;
    raw_len   = pos_next;
    if (item_i.data_byte == 8'd0 && raw_len != '0) begin
      raw_len = raw_len - POS_W'(1);
    end
    if (raw_len > cap - POS_W'(1)) begin
      raw_len = cap - POS_W'(1);
    end

    if (item_i.has_byte) begin
      case (phase_q)
        idtlv_pkg::PH_TYPE: begin
          type_d  = item_i.data_byte;
          phase_d = idtlv_pkg::PH_LEN_HI;
        end
        idtlv_pkg::PH_LEN_HI: begin
          left_d  = {item_i.data_byte, 8'd0};
          phase_d = idtlv_pkg::PH_LEN_LO;
        end
        idtlv_pkg::PH_LEN_LO: begin
          left_d = len_full;
          pos_d  = '0;
          if (type_q != idtlv_pkg::TYPE_RANDOM && count_q != idtlv_pkg::COUNT_MAX) begin
            count_d = count_q + 16'd1;
          end
          if (len_full == '0) begin
            // Empty value: open and close the field at once
            if (type_dest != idtlv_pkg::DEST_NONE) begin
              result_o.dest        = type_dest;
              result_o.field_start = 1'b1;
              result_o.field_end   = 1'b1;
            end
            dest_d  = idtlv_pkg::DEST_NONE;
            phase_d = idtlv_pkg::PH_TYPE;
          end else begin
            dest_d  = type_dest;
            phase_d = idtlv_pkg::PH_VALUE;
          end
        end
        default: begin
          if (cur_dest != idtlv_pkg::DEST_NONE) begin
            result_o.dest        = cur_dest;
            result_o.field_start = (pos_q == '0);
            if (pos_q < cap - POS_W'(1)) begin
              result_o.write_enable = 1'b1;
              result_o.write_byte   = item_i.data_byte;
              result_o.write_index  = 9'(pos_q);
            end
          end
          pos_d  = pos_next;
          left_d = left_next;
          dest_d = cur_dest;
          if (left_next == '0) begin
            // Close the value, dropping a trailing NUL
            if (cur_dest != idtlv_pkg::DEST_NONE) begin
              result_o.field_end    = 1'b1;
              result_o.field_length = 9'(raw_len);
            end
            dest_d  = idtlv_pkg::DEST_NONE;
            phase_d = idtlv_pkg::PH_TYPE;
          end
        end
      endcase
    end

    result_o.field_count = count_d;

    // Close the block and return to the reset state
    if (item_i.last_byte) begin
      result_o.block_done = 1'b1;
      if (phase_d != idtlv_pkg::PH_TYPE) begin
        result_o.status = idtlv_pkg::STATUS_TRUNCATED;
      end else if (count_d == '0) begin
        result_o.status = idtlv_pkg::STATUS_NO_FIELDS;
      end else begin
        result_o.status = idtlv_pkg::STATUS_OK;
      end
      phase_d = idtlv_pkg::PH_TYPE;
      type_d  = '0;
      left_d  = '0;
      dest_d  = idtlv_pkg::DEST_NONE;
      pos_d   = '0;
      count_d = '0;
    end
  end

  // Advance parser state on each beat that moves to the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= idtlv_pkg::PH_TYPE;
      type_q  <= '0;
      left_q  <= '0;
      dest_q  <= idtlv_pkg::DEST_NONE;
      pos_q   <= '0;
      count_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      left_q  <= left_d;
      dest_q  <= dest_d;
      pos_q   <= pos_d;
      count_q <= count_d;
    end
  end

`ifndef ASSERT_OFF
  // A destination is only live while a value is being read
  a_dest_in_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != idtlv_pkg::PH_VALUE |-> dest_q == idtlv_pkg::DEST_NONE)
    else $error("destination held outside a value");

  // A write always names a string
  a_write_has_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.write_enable |-> result_o.dest != idtlv_pkg::DEST_NONE)
    else $error("write without destination");

  // The end of a block clears the parser
  a_block_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.last_byte |=> phase_q == idtlv_pkg::PH_TYPE && count_q == '0)
    else $error("state not cleared after block end");

  // Stored position never passes the largest capacity
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(MAX_CAP))
    else $error("store position out of range");
`endif

endmodule

// ----- sv/identity_tlv_stream_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// identity_tlv_stream_parser
// Parses type/length/value records of an identity block into string writes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one byte of the identity block per beat. tuser set means
//   the byte is valid; a beat with tuser clear and tlast set closes an empty
//   block. tlast marks the final beat of the block.
//   Master channel: exactly one result beat per input beat, in order. tuser
//   carries the destination string, tlast marks the end of the block, and
//   tdata the write, field start/end, length, status and record count.
//   Path: a beat passes through the input register and then the result
//   register before it is presented on the master channel.
//   Throughput: one beat per cycle unless the receiver stalls; each
//   register takes a new beat whenever its current one moves on.
//   Reset: all parser state returns to the start of a block and both
//   registers empty. After each tlast beat the parser returns to that state.
//   Stall: while the receiver holds m_axis_tready low the result register
//   holds, the input register fills, and s_axis_tready then falls.
// ----------------------------------------------------------------------------
module identity_tlv_stream_parser #(
  parameter int unsigned NAME_CAPACITY   = 256,
  parameter int unsigned GROUPS_CAPACITY = 512,
  parameter int unsigned HOST_CAPACITY   = 256,
  parameter int unsigned IP_CAPACITY     = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [0] write_enable, [8:1] write_byte,
                                      // [17:9] write_index, [18] field_start,
                                      // [19] field_end, [28:20] field_length,
                                      // [30:29] status, [46:31] field_count,
                                      // [47] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] dest
  output logic        m_axis_tlast    // block_done
);

  localparam int unsigned ITEM_W   = $bits(idtlv_pkg::item_t);
  localparam int unsigned RESULT_W = $bits(idtlv_pkg::result_t);

  idtlv_pkg::item_t   in_item, held_item;
  idtlv_pkg::result_t core_result, out_result;
  logic               held_valid;
  logic               out_ready;

  assign in_item.last_byte = s_axis_tlast;
  assign in_item.has_byte  = s_axis_tuser;
  assign in_item.data_byte = s_axis_tdata;

  // Input register
  idtlv_slice #(
    .W (ITEM_W)
  ) u_in_slice (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (in_item),
    .valid_o (held_valid),
    .ready_i (out_ready),
    .data_o  (held_item)
  );

  // Parser state and result logic
  idtlv_core #(
    .NAME_CAPACITY   (NAME_CAPACITY),
    .GROUPS_CAPACITY (GROUPS_CAPACITY),
    .HOST_CAPACITY   (HOST_CAPACITY),
    .IP_CAPACITY     (IP_CAPACITY)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (held_valid && out_ready),
    .item_i   (held_item),
    .result_o (core_result)
  );

  // Result register
  idtlv_slice #(
    .W (RESULT_W)
  ) u_out_slice (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (held_valid),
    .ready_o (out_ready),
    .data_i  (core_result),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_result)
  );

  // Pack the result beat
  assign m_axis_tdata = {1'b0,
                         out_result.field_count,
                         out_result.status,
                         out_result.field_length,
                         out_result.field_end,
                         out_result.field_start,
                         out_result.write_index,
                         out_result.write_byte,
                         out_result.write_enable};
  assign m_axis_tuser = out_result.dest;
  assign m_axis_tlast = out_result.block_done;

endmodule
